>>> design/atlf_pkg.sv
// Shared types and constants for the AT response line framer.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package atlf_pkg;

   // Message buffer size in bytes per bank.
   localparam int BUFFER_BYTES = 64;
   localparam int FILL_W       = $clog2(BUFFER_BYTES + 1);
   localparam int HDR_LEN      = 6;

   typedef logic [7:0]        byte_type;
   typedef logic [FILL_W-1:0] fill_type;

   localparam byte_type BYTE_CR     = 8'h0D;
   localparam byte_type BYTE_LF     = 8'h0A;
   localparam byte_type BYTE_PROMPT = 8'h3E;
   localparam byte_type BYTE_ZERO   = 8'h30;
   localparam byte_type BYTE_NINE   = 8'h39;

   // Result item, registered as one word.
   typedef struct packed {
      logic       prompt_seen;
      logic       stored;
      logic       store_bank;
      logic [5:0] store_index;
      byte_type   store_value;
      logic       message_done;
      logic       message_bank;
      logic [6:0] message_length;
      logic       header_seen;
      byte_type   header_count;
      logic       overflow;
   } rsp_type;

   // Characters of the "+RECV:" header, by position.
   function automatic byte_type hdr_char(input logic [2:0] idx);
      byte_type ch;
      unique case (idx)
         3'd0:    ch = 8'h2B;
         3'd1:    ch = 8'h52;
         3'd2:    ch = 8'h45;
         3'd3:    ch = 8'h43;
         3'd4:    ch = 8'h56;
         3'd5:    ch = 8'h3A;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> design/atlf_if.sv
// Valid/ready channel interfaces for the framer: received bytes in, results out.
// Depends on atlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface atlf_req_if;
   import atlf_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atlf_rsp_if;
   import atlf_pkg::*;

   logic       valid;
   logic       ready;
   logic       prompt_seen;
   logic       stored;
   logic       store_bank;
   logic [5:0] store_index;
   byte_type   store_value;
   logic       message_done;
   logic       message_bank;
   logic [6:0] message_length;
   logic       header_seen;
   byte_type   header_count;
   logic       overflow;

   modport source (
      output valid, input ready,
      output prompt_seen, stored, store_bank, store_index, store_value,
      output message_done, message_bank, message_length,
      output header_seen, header_count, overflow
   );
   modport sink (
      input valid, output ready,
      input prompt_seen, stored, store_bank, store_index, store_value,
      input message_done, message_bank, message_length,
      input header_seen, header_count, overflow
   );
endinterface

`default_nettype wire

>>> design/at_response_line_framer_core.sv
// AT response line framer core: frames bytes from a radio module into messages.
// Depends on atlf_pkg and atlf_if (atlf_req_if, atlf_rsp_if).
// Path: an accepted request passes the input register, then the result register.
// Throughput: one request per cycle while the result side is ready; the state update
// is a single short pass between the input register and the result register.
// Reset: synchronous, active high; clears fill, count, bank and line tracking.
`timescale 1ns / 1ps
`default_nettype none

module at_response_line_framer_core (
   input  wire logic      clock,
   input  wire logic      reset,
   atlf_req_if.sink       req_chan,
   atlf_rsp_if.source     rsp_chan
);
   import atlf_pkg::*;

   // input register
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff;

   // framer state
   fill_type fill_ff, fill_in;
   byte_type remain_ff, remain_in;     // payload bytes still to come
   logic     bank_ff, bank_in;         // ping-pong bank being filled
   logic     cr_ff, cr_in;             // previous byte was CR
   logic     prefix_ff, prefix_in;     // line still matches "+RECV:"
   byte_type acc_ff, acc_in;           // decimal count, mod 256
   logic     digits_ff, digits_in;     // still inside the digit run

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  res_ff, res_in;

   logic     advance;
   fill_type fill_inc;
   byte_type b;
   logic     is_digit;

   // The input stage moves on whenever the result slot is free or being taken.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in  = (req_chan.valid && req_chan.ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   assign b        = in_byte_ff;
   assign fill_inc = fill_ff + fill_type'(1);
   assign is_digit = (b >= BYTE_ZERO) && (b <= BYTE_NINE);

   always_comb begin
      fill_in   = fill_ff;
      remain_in = remain_ff;
      bank_in   = bank_ff;
      cr_in     = cr_ff;
      prefix_in = prefix_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      res_in    = '0;

      if (fill_ff >= fill_type'(BUFFER_BYTES)) begin
         // full: drop the byte, restart the line, keep any payload count
         res_in.overflow = 1'b1;
         fill_in   = '0;
         cr_in     = 1'b0;
         prefix_in = 1'b1;
         acc_in    = '0;
         digits_in = 1'b1;
      end else if (b == BYTE_PROMPT) begin
         // send prompt: flagged only, tracking untouched
         res_in.prompt_seen = 1'b1;
      end else begin
         res_in.stored      = 1'b1;
         res_in.store_bank  = bank_ff;
         res_in.store_index = fill_ff[5:0];
         res_in.store_value = b;
         fill_in            = fill_inc;

         if (remain_ff != '0) begin
            // payload byte: count down, close the message on the last one
            remain_in = remain_ff - 8'd1;
            if (remain_ff == 8'd1) begin
               res_in.message_done   = 1'b1;
               res_in.message_bank   = bank_ff;
               res_in.message_length = 7'(fill_inc);
               bank_in   = !bank_ff;
               fill_in   = '0;
               cr_in     = 1'b0;
               prefix_in = 1'b1;
               acc_in    = '0;
               digits_in = 1'b1;
            end
         end else begin
            // line mode: header match in the first six bytes, digits after
            if (fill_ff < fill_type'(HDR_LEN)) begin
               if (b != hdr_char(fill_ff[2:0]))
                  prefix_in = 1'b0;
            end else if (digits_ff) begin
               if (is_digit)
                  acc_in = {acc_ff[4:0], 3'b000} + {acc_ff[6:0], 1'b0} + (b - BYTE_ZERO);
               else
                  digits_in = 1'b0;
            end

            if (b == BYTE_LF && cr_ff && fill_ff != '0) begin
               if (fill_inc > fill_type'(HDR_LEN) && prefix_in) begin
                  // header line: load the payload count, keep the header bytes
                  remain_in           = acc_in;
                  res_in.header_seen  = 1'b1;
                  res_in.header_count = acc_in;
                  cr_in               = 1'b0;
               end else begin
                  if (fill_inc > fill_type'(2)) begin
                     res_in.message_done   = 1'b1;
                     res_in.message_bank   = bank_ff;
                     res_in.message_length = 7'(fill_inc);
                     bank_in = !bank_ff;
                  end
                  // a bare CR LF is simply discarded
                  fill_in   = '0;
                  cr_in     = 1'b0;
                  prefix_in = 1'b1;
                  acc_in    = '0;
                  digits_in = 1'b1;
               end
            end else begin
               cr_in = (b == BYTE_CR);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         remain_ff    <= '0;
         bank_ff      <= 1'b0;
         cr_ff        <= 1'b0;
         prefix_ff    <= 1'b1;
         acc_ff       <= '0;
         digits_ff    <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            fill_ff   <= fill_in;
            remain_ff <= remain_in;
            bank_ff   <= bank_in;
            cr_ff     <= cr_in;
            prefix_ff <= prefix_in;
            acc_ff    <= acc_in;
            digits_ff <= digits_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready)
         in_byte_ff <= req_chan.rx_byte;
      if (advance)
         res_ff <= res_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.prompt_seen    = res_ff.prompt_seen;
   assign rsp_chan.stored         = res_ff.stored;
   assign rsp_chan.store_bank     = res_ff.store_bank;
   assign rsp_chan.store_index    = res_ff.store_index;
   assign rsp_chan.store_value    = res_ff.store_value;
   assign rsp_chan.message_done   = res_ff.message_done;
   assign rsp_chan.message_bank   = res_ff.message_bank;
   assign rsp_chan.message_length = res_ff.message_length;
   assign rsp_chan.header_seen    = res_ff.header_seen;
   assign rsp_chan.header_count   = res_ff.header_count;
   assign rsp_chan.overflow       = res_ff.overflow;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fill_type'(BUFFER_BYTES))
      else $error("fill level beyond buffer size");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({res_ff.prompt_seen, res_ff.stored, res_ff.overflow}) == 1)
      else $error("result must be exactly one of prompt, store, overflow");

   a_done_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.message_done |-> res_ff.stored && !res_ff.header_seen)
      else $error("completed message without a stored byte or with a header");

   a_bank_flip: assert property (@(posedge clock) disable iff (reset)
      advance && res_in.message_done |=> bank_ff != $past(bank_ff))
      else $error("bank did not flip on message completion");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_at_response_line_framer_core.sv
// Self-checking bench for at_response_line_framer_core: byte requests in, framing results out.
// Depends on atlf_pkg, atlf_if (atlf_req_if, atlf_rsp_if) and the core itself.
`timescale 1ns / 1ps

module tb_at_response_line_framer_core;
   import atlf_pkg::*;

   localparam int IDLE_LIMIT = 1000;   // cycles with no handshake at all before giving up
   localparam int DRAIN_WAIT = 10;     // settle wait after the drain; allow a generous margin
   localparam int RANDOM_REQS = 300;

   // Header tag, first character in the top byte.
   localparam logic [47:0] RECV_TAG = "+RECV:";

   logic clock = 1'b0;
   logic reset;

   atlf_req_if req_chan ();
   atlf_rsp_if rsp_chan ();

   at_response_line_framer_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Framer model: own copy of the line/payload tracking state.
   // ------------------------------------------------------------------
   fill_type fr_fill;
   byte_type fr_payload_left;
   logic     fr_bank;
   logic     fr_last_cr;
   logic     fr_tag_ok;
   byte_type fr_count;
   logic     fr_digits_open;

   function automatic void restart_line();
      fr_fill        = '0;
      fr_last_cr     = 1'b0;
      fr_tag_ok      = 1'b1;
      fr_count       = '0;
      fr_digits_open = 1'b1;
   endfunction

   // Works out the result of one accepted byte and advances the model state.
   function automatic rsp_type frame_byte(input byte_type b);
      rsp_type  r;
      fill_type pos;
      r = '0;
      // Full buffer: byte dropped (even a prompt), line restarts, payload count survives.
      if (fr_fill >= BUFFER_BYTES) begin
         r.overflow = 1'b1;
         restart_line();
         return r;
      end
      // Prompt is only flagged; tracking untouched.
      if (b == BYTE_PROMPT) begin
         r.prompt_seen = 1'b1;
         return r;
      end
      pos           = fr_fill;
      r.stored      = 1'b1;
      r.store_bank  = fr_bank;
      r.store_index = pos[5:0];
      r.store_value = b;
      fr_fill       = pos + 1'b1;

      // Payload bytes after a header: count down, hand the message over at zero.
      if (fr_payload_left != 0) begin
         fr_payload_left = fr_payload_left - 1'b1;
         if (fr_payload_left == 0) begin
            r.message_done   = 1'b1;
            r.message_bank   = fr_bank;
            r.message_length = fr_fill;
            fr_bank          = ~fr_bank;
            restart_line();
         end
         return r;
      end

      // Line mode: tag match over the first six bytes, then decimal digits.
      if (pos < HDR_LEN) begin
         if (b != RECV_TAG[8*(HDR_LEN-1-pos) +: 8])
            fr_tag_ok = 1'b0;
      end else if (fr_digits_open) begin
         if (b >= BYTE_ZERO && b <= BYTE_NINE)
            fr_count = fr_count * 8'd10 + (b - BYTE_ZERO);
         else
            fr_digits_open = 1'b0;
      end

      // CR LF ending; a single-byte line can never qualify.
      if (b == BYTE_LF && fr_last_cr && pos >= 1) begin
         if (fr_fill > HDR_LEN && fr_tag_ok) begin
            fr_payload_left = fr_count;
            r.header_seen   = 1'b1;
            r.header_count  = fr_count;
            fr_last_cr      = 1'b0;
         end else if (fr_fill > 2) begin
            r.message_done   = 1'b1;
            r.message_bank   = fr_bank;
            r.message_length = fr_fill;
            fr_bank          = ~fr_bank;
            restart_line();
         end else begin
            restart_line();   // bare CR LF, thrown away
         end
      end else begin
         fr_last_cr = (b == BYTE_CR);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps between them.
   // ------------------------------------------------------------------
   byte_type rx_pending[$];   // bytes still to be offered
   rsp_type  resp_due[$];     // results owed by the core, oldest first
   int       burst_left = 0;
   int       gap_left   = 0;
   int       mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         fr_payload_left = '0;
         fr_bank         = 1'b0;
         restart_line();
      end else begin
         if (req_chan.valid && req_chan.ready)
            resp_due.push_back(frame_byte(req_chan.rx_byte));
         // Only move on once the current request (if any) has gone.
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (rx_pending.size() > 0) begin
               req_chan.valid   <= 1'b1;
               req_chan.rx_byte <= rx_pending.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side: ready cycles through four back-pressure patterns.
   // ------------------------------------------------------------------
   int ready_tick = 0;

   always @(posedge clock) begin
      ready_tick++;
      case ((ready_tick / 150) % 4)
         0: rsp_chan.ready <= 1'b1;                          // no back-pressure
         1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);   // light random stalls
         2: rsp_chan.ready <= ((ready_tick % 5) != 4);       // periodic stall
         default: rsp_chan.ready <= 1'($urandom_range(0, 1));   // heavy random stalls
      endcase
   end

   // ------------------------------------------------------------------
   // Monitor: each accepted result against the oldest expectation.
   // ------------------------------------------------------------------
   rsp_type want;

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (resp_due.size() == 0) begin
            $error("result with no request outstanding");
            mismatches++;
         end else begin
            want = resp_due.pop_front();
            check_field("prompt_seen",    want.prompt_seen,    rsp_chan.prompt_seen);
            check_field("stored",         want.stored,         rsp_chan.stored);
            check_field("store_bank",     want.store_bank,     rsp_chan.store_bank);
            check_field("store_index",    want.store_index,    rsp_chan.store_index);
            check_field("store_value",    want.store_value,    rsp_chan.store_value);
            check_field("message_done",   want.message_done,   rsp_chan.message_done);
            check_field("message_bank",   want.message_bank,   rsp_chan.message_bank);
            check_field("message_length", want.message_length, rsp_chan.message_length);
            check_field("header_seen",    want.header_seen,    rsp_chan.header_seen);
            check_field("header_count",   want.header_count,   rsp_chan.header_count);
            check_field("overflow",       want.overflow,       rsp_chan.overflow);
         end
      end
   end

   // Watchdog: any handshake on either side counts as progress.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic queue_str(input string s);
      for (int i = 0; i < s.len(); i++)
         rx_pending.push_back(byte_type'(s[i]));
   endtask

   initial begin
      int       pick;
      int       n;
      int       len;
      int       spot;
      int       target;
      string    s;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      rsp_chan.ready   = 1'b0;

      // Directed: prompt, bare CR LF, plain line, one-byte start then CR LF.
      queue_str(">");
      queue_str("\r\n");
      queue_str("OK\r\n");
      queue_str("\n\r\n");
      // Header with a non-digit ending the count, payload holding extremes and
      // a prompt (not stored, not counted), ending on a CR.
      queue_str("+RECV:3,\r\n");
      rx_pending.push_back(8'hFF);
      rx_pending.push_back(BYTE_PROMPT);
      rx_pending.push_back(8'h00);
      rx_pending.push_back(BYTE_CR);
      // Count wraps modulo 256: 258 -> 2.
      queue_str("+RECV:258\r\nab");
      // Header without digits: count zero, later lines reload it and finish nothing,
      // so the buffer fills; a prompt at the full mark is dropped as overflow.
      queue_str("+RECV:\r\n");
      queue_str("x\r\n");
      for (int i = 11; i < BUFFER_BYTES; i++)
         rx_pending.push_back(8'h41 + i[3:0]);
      rx_pending.push_back(BYTE_PROMPT);

      // Random traffic, mostly well-formed header/payload and text lines.
      target = rx_pending.size() + RANDOM_REQS;
      while (rx_pending.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // Header plus payload.
            spot = $urandom_range(0, 19);
            if (spot < 14)      n = $urandom_range(1, 30);
            else if (spot < 16) n = 0;
            else if (spot < 18) n = $urandom_range(256, 300);
            else if (spot < 19) n = $urandom_range(31, 60);
            else                n = $urandom_range(61, 255);
            s = (spot == 14) ? "+RECV:" : $sformatf("+RECV:%0d", n);
            if ($urandom_range(0, 1)) s = {s, ",x"};
            queue_str({s, "\r\n"});
            if (spot == 14) n = 0;
            repeat (n % 256)
               rx_pending.push_back(byte_type'($urandom_range(0, 255)));
         end else if (pick < 75) begin
            // Text line; now and then long enough to overflow.
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(58, 70) : $urandom_range(1, 20);
            repeat (len)
               rx_pending.push_back(($urandom_range(0, 9) == 0)
                                    ? BYTE_CR
                                    : byte_type'($urandom_range(8'h20, 8'h7E)));
            queue_str("\r\n");
         end else if (pick < 85) begin
            // Header tag with one character spoilt, then a short tail.
            spot = $urandom_range(0, HDR_LEN - 1);
            for (int i = 0; i < HDR_LEN; i++)
               rx_pending.push_back((i == spot) ? byte_type'($urandom_range(0, 255))
                                                : RECV_TAG[8*(HDR_LEN-1-i) +: 8]);
            repeat ($urandom_range(0, 4))
               rx_pending.push_back(byte_type'($urandom_range(8'h30, 8'h39)));
            queue_str("\r\n");
         end else if (pick < 90) begin
            if ($urandom_range(0, 1))
               queue_str("\r\n");
            else
               queue_str(">");
         end else begin
            // Raw noise, any byte value.
            repeat ($urandom_range(1, 8))
               rx_pending.push_back(byte_type'($urandom_range(0, 255)));
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Drain: every request sent and every result back, then a short settle.
      while (rx_pending.size() != 0 || req_chan.valid || resp_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0 && resp_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
